@@ src/gffr_pkg.sv @@
// Shared types and constants for the grid first-fit rectangle placer.
package gffr_pkg;

    localparam int FIELD_W = 4;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_PLACE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Operations after classification
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_PLACE = 2'd2,
        OP_FAIL  = 2'd3
    } op_t;

    // One classified command
    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
    } desc_t;

    // Queue to back end
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_out_t;

    // Back-side execution states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_RES  = 2'd2
    } state_t;

endpackage

@@ src/grid_first_fit_rect_placer.sv @@
// Top level of the grid first-fit rectangle placer.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_cmd s_col s_row s_width s_height
//   m_        out        m_valid / m_ready  m_ok m_out_col m_out_row
//
// Clear, mark and rejected commands are completed by the back end straight from its idle state.
// Place scans one grid row per cycle with all columns tested in parallel,
// and stops at the first row where a window fits or after the last row.
// Reset (aresetn low, synchronous) empties the bitmap, queue and result.
// A two-entry queue lets the front accept while the back end scans or the
// result register waits on m_ready.
module grid_first_fit_rect_placer
    import gffr_pkg::*;
#(
    parameter int GRID_SIZE = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [FIELD_W-1:0] s_col,
    input  logic [FIELD_W-1:0] s_row,
    input  logic [FIELD_W-1:0] s_width,
    input  logic [FIELD_W-1:0] s_height,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [FIELD_W-1:0] m_out_col,
    output logic [FIELD_W-1:0] m_out_row
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    desc_t  q_desc;
    q_out_t q_head;

    gffr_front #(
        .GRID_SIZE(GRID_SIZE)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_col   (s_col),
        .s_row   (s_row),
        .s_width (s_width),
        .s_height(s_height),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_desc  (q_desc)
    );

    gffr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_desc(q_desc),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    gffr_back #(
        .GRID_SIZE(GRID_SIZE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .pop      (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_ok     (m_ok),
        .m_out_col(m_out_col),
        .m_out_row(m_out_row)
    );

endmodule

@@ src/gffr_front.sv @@
// Front end: decode and range-check each command before queueing it.
module gffr_front
    import gffr_pkg::*;
#(
    parameter int GRID_SIZE = 10
) (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [FIELD_W-1:0] s_col,
    input  logic [FIELD_W-1:0] s_row,
    input  logic [FIELD_W-1:0] s_width,
    input  logic [FIELD_W-1:0] s_height,
    input  logic               q_full,
    output logic               q_push,
    output desc_t              q_desc
);

    localparam int SW = FIELD_W + 2;
    localparam logic [SW-1:0] GRID = SW'(GRID_SIZE);

    logic nonzero;
    logic mark_fits;
    logic place_fits;

    // Accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign nonzero    = (s_width != '0) && (s_height != '0);
    assign mark_fits  = nonzero
                        && (SW'(s_col) + SW'(s_width) <= GRID)
                        && (SW'(s_row) + SW'(s_height) <= GRID);
    assign place_fits = nonzero && (SW'(s_width) <= GRID) && (SW'(s_height) <= GRID);

    // Classify the command
    always_comb begin
        q_desc.col    = s_col;
        q_desc.row    = s_row;
        q_desc.width  = s_width;
        q_desc.height = s_height;
        unique case (cmd_t'(s_cmd))
            CMD_CLEAR: q_desc.op = OP_CLEAR;
            CMD_MARK:  q_desc.op = mark_fits ? OP_MARK : OP_FAIL;
            CMD_PLACE: q_desc.op = place_fits ? OP_PLACE : OP_FAIL;
            default:   q_desc.op = OP_FAIL;
        endcase
    end

endmodule

@@ src/gffr_queue.sv @@
// Two-entry command queue between front and back ends.
module gffr_queue
    import gffr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  desc_t  push_desc,
    output logic   full,
    input  logic   pop,
    output q_out_t head
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ src/gffr_back.sv @@
// Back end: occupancy bitmap, row-by-row first-fit scan and result register.
module gffr_back
    import gffr_pkg::*;
#(
    parameter int GRID_SIZE = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  q_out_t             head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [FIELD_W-1:0] m_out_col,
    output logic [FIELD_W-1:0] m_out_row
);

    localparam int G  = GRID_SIZE;
    localparam int RW = $clog2(G);
    localparam int CW = $clog2(G + 1);
    localparam int AW = (CW + 1 > FIELD_W + 1) ? CW + 1 : FIELD_W + 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(G - 1);

    // Run of n ones at the bottom of a grid-wide row
    function automatic logic [G-1:0] ones_mask(input logic [CW-1:0] n);
        logic [G:0] t;
        t = ((G + 1)'(1) << n) - (G + 1)'(1);
        return t[G-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [G-1:0]       occ_reg [G];
    logic [G-1:0]       occ_next [G];
    logic [CW-1:0]      run_reg [G];
    logic [CW-1:0]      run_next [G];
    logic [CW-1:0]      runs [G];
    logic [RW-1:0]      r_reg, r_next;
    logic [CW-1:0]      w_reg, w_next;
    logic [CW-1:0]      h_reg, h_next;
    logic               res_ok_reg, res_ok_next;
    logic [FIELD_W-1:0] res_col_reg, res_col_next;
    logic [FIELD_W-1:0] res_row_reg, res_row_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg, m_ok_next;
    logic [FIELD_W-1:0] m_col_reg, m_col_next;
    logic [FIELD_W-1:0] m_row_reg, m_row_next;

    logic               out_free;
    logic [G-1:0]       cur_row;
    logic [G-1:0]       col_free;
    logic [G-1:0]       fits;
    logic [G-1:0]       wm;
    logic               any_fit;
    logic [RW-1:0]      hit_x;
    logic               candidate;
    logic [AW-1:0]      top_y;
    logic               set_en;
    logic [AW-1:0]      set_top;
    logic [AW-1:0]      set_h;
    logic [G-1:0]       set_mask;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_ok      = m_ok_reg;
    assign m_out_col = m_col_reg;
    assign m_out_row = m_row_reg;

    // Column-parallel test of the window ending at the current row
    always_comb begin
        cur_row = occ_reg[r_reg];
        wm      = ones_mask(w_reg);
        for (int c = 0; c < G; c++) begin
            if (cur_row[c]) begin
                runs[c] = '0;
            end else if (run_reg[c] == h_reg) begin
                runs[c] = h_reg;
            end else begin
                runs[c] = run_reg[c] + CW'(1);
            end
            col_free[c] = (runs[c] == h_reg);
        end
        for (int x = 0; x < G; x++) begin
            fits[x] = (((col_free >> x) & wm) == wm);
        end
        any_fit = |fits;
        hit_x   = '0;
        for (int x = G - 1; x >= 0; x--) begin
            if (fits[x]) begin
                hit_x = RW'(x);
            end
        end
        candidate = (AW'(r_reg) + AW'(1) >= AW'(h_reg));
        top_y     = AW'(r_reg) + AW'(1) - AW'(h_reg);
    end

    // Sequencer, bitmap update and result staging
    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        occ_next     = occ_reg;
        run_next     = run_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        res_ok_next  = res_ok_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_ok_next    = m_ok_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        set_en       = 1'b0;
        set_top      = '0;
        set_h        = '0;
        set_mask     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid && out_free) begin
                    pop = 1'b1;
                    if (head.desc.op == OP_PLACE) begin
                        w_next     = CW'(head.desc.width);
                        h_next     = CW'(head.desc.height);
                        r_next     = '0;
                        for (int c = 0; c < G; c++) begin
                            run_next[c] = '0;
                        end
                        state_next = ST_SCAN;
                    end else begin
                        m_valid_next = 1'b1;
                        m_col_next   = '0;
                        m_row_next   = '0;
                        m_ok_next    = (head.desc.op != OP_FAIL);
                        if (head.desc.op == OP_CLEAR) begin
                            for (int i = 0; i < G; i++) begin
                                occ_next[i] = '0;
                            end
                        end
                        if (head.desc.op == OP_MARK) begin
                            set_en   = 1'b1;
                            set_top  = AW'(head.desc.row);
                            set_h    = AW'(head.desc.height);
                            set_mask = ones_mask(CW'(head.desc.width)) << head.desc.col;
                        end
                    end
                end
            end
            ST_SCAN: begin
                run_next = runs;
                if (candidate && any_fit) begin
                    set_en       = 1'b1;
                    set_top      = top_y;
                    set_h        = AW'(h_reg);
                    set_mask     = wm << hit_x;
                    res_ok_next  = 1'b1;
                    res_col_next = FIELD_W'(hit_x);
                    res_row_next = FIELD_W'(top_y);
                    state_next   = ST_RES;
                end else if (r_reg == LAST_ROW) begin
                    res_ok_next  = 1'b0;
                    res_col_next = '0;
                    res_row_next = '0;
                    state_next   = ST_RES;
                end else begin
                    r_next = r_reg + RW'(1);
                end
            end
            ST_RES: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_col_next   = res_col_reg;
                    m_row_next   = res_row_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Set the rectangle rows in parallel
        for (int i = 0; i < G; i++) begin
            if (set_en && (AW'(i) >= set_top) && (AW'(i) < set_top + set_h)) begin
                occ_next[i] = occ_next[i] | set_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < G; i++) begin
                occ_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            occ_reg     <= occ_next;
        end
    end

    // Hold scan and result payload
    always_ff @(posedge aclk) begin
        run_reg     <= run_next;
        r_reg       <= r_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        res_ok_reg  <= res_ok_next;
        res_col_reg <= res_col_next;
        res_row_reg <= res_row_next;
        m_ok_reg    <= m_ok_next;
        m_col_reg   <= m_col_next;
        m_row_reg   <= m_row_next;
    end

endmodule

@@ sim/tb_grid_first_fit_rect_placer.sv @@
// Self-checking testbench for the grid first-fit rectangle placer.
module tb_grid_first_fit_rect_placer;
    import gffr_pkg::*;

    localparam int GRID         = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = GRID + 8;
    localparam int HOLD_CYCLES  = 300;

    // One result as it leaves the block
    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] row;
    } placement_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [FIELD_W-1:0] s_col;
    logic [FIELD_W-1:0] s_row;
    logic [FIELD_W-1:0] s_width;
    logic [FIELD_W-1:0] s_height;
    logic               m_valid;
    logic               m_ready;
    logic               m_ok;
    logic [FIELD_W-1:0] m_out_col;
    logic [FIELD_W-1:0] m_out_row;

    // Shadow copy of the occupancy bitmap
    logic [GRID-1:0] occ_map [GRID];

    placement_t pending_results [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int recv_hold      = 0;
    int err_count      = 0;
    int cycle_count    = 0;
    int n_clear        = 0;
    int n_mark_ok      = 0;
    int n_place_ok     = 0;
    int n_rejected     = 0;
    int n_checked      = 0;

    grid_first_fit_rect_placer #(
        .GRID_SIZE (GRID)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_col     (s_col),
        .s_row     (s_row),
        .s_width   (s_width),
        .s_height  (s_height),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_ok      (m_ok),
        .m_out_col (m_out_col),
        .m_out_row (m_out_row)
    );

    // Clock generation
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_grid_first_fit_rect_placer: FAIL");
            $finish;
        end
    end

    // Run of w ones starting at column x
    function automatic logic [GRID-1:0] span_bits(int x, int w);
        logic [GRID-1:0] m;
        m = '0;
        for (int i = x; i < x + w; i++) m[i] = 1'b1;
        return m;
    endfunction

    function automatic bit area_free(int x, int y, int w, int h);
        for (int j = 0; j < h; j++) begin
            if ((occ_map[y + j] & span_bits(x, w)) != '0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void area_take(int x, int y, int w, int h);
        for (int j = 0; j < h; j++) occ_map[y + j] |= span_bits(x, w);
    endfunction

    // Update the bitmap for one command and return its result
    function automatic placement_t predict_placement(cmd_t cmd, int col, int row,
                                                     int w, int h);
        placement_t p;
        bit         found;
        p     = '0;
        found = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                for (int r = 0; r < GRID; r++) occ_map[r] = '0;
                p.ok = 1'b1;
                n_clear++;
            end
            CMD_MARK: begin
                if (w != 0 && h != 0 && col + w <= GRID && row + h <= GRID) begin
                    area_take(col, row, w, h);
                    p.ok = 1'b1;
                    n_mark_ok++;
                end else begin
                    n_rejected++;
                end
            end
            CMD_PLACE: begin
                if (w != 0 && h != 0 && w <= GRID && h <= GRID) begin
                    // Top rows first, left columns first within a row
                    for (int y = 0; y + h <= GRID && !found; y++) begin
                        for (int x = 0; x + w <= GRID && !found; x++) begin
                            if (area_free(x, y, w, h)) begin
                                area_take(x, y, w, h);
                                found = 1'b1;
                                p.ok  = 1'b1;
                                p.col = FIELD_W'(x);
                                p.row = FIELD_W'(y);
                            end
                        end
                    end
                end
                if (found) n_place_ok++;
                else n_rejected++;
            end
            default: begin
                n_rejected++;
            end
        endcase
        return p;
    endfunction

    // Offer one command, hold it until the transfer, then log the expected result
    task automatic send_cmd(cmd_t cmd, logic [FIELD_W-1:0] col, logic [FIELD_W-1:0] row,
                            logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_col    <= col;
        s_row    <= row;
        s_width  <= w;
        s_height <= h;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_placement(cmd, col, row, w, h));
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        placement_t want;
        n_checked++;
        if (pending_results.size() == 0) begin
            $error("result with none expected: ok=%0d out_col=%0d out_row=%0d",
                   m_ok, m_out_col, m_out_row);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            if (m_ok !== want.ok) begin
                $error("ok: expected %0d, got %0d", want.ok, m_ok);
                err_count++;
            end
            if (m_out_col !== want.col) begin
                $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                err_count++;
            end
            if (m_out_row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                err_count++;
            end
        end
    endtask

    // Result side: check each transfer, then pick ready for the next cycle
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result();
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Edges of the fields, every command and the corner cases
    task automatic test_directed();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_cmd(CMD_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd10, 4'd10);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd1, 4'd1);
        send_cmd(CMD_CLEAR, 4'd15, 4'd15, 4'd15, 4'd15);
        send_cmd(CMD_MARK, 4'd9, 4'd9, 4'd1, 4'd1);
        send_cmd(CMD_MARK, 4'd9, 4'd0, 4'd2, 4'd1);
        send_cmd(CMD_MARK, 4'd0, 4'd5, 4'd1, 4'd6);
        send_cmd(CMD_MARK, 4'd2, 4'd2, 4'd0, 4'd3);
        send_cmd(CMD_MARK, 4'd2, 4'd2, 4'd3, 4'd0);
        send_cmd(CMD_MARK, 4'd15, 4'd15, 4'd15, 4'd15);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd2);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd2, 4'd0);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd11, 4'd1);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd1, 4'd11);
        send_cmd(CMD_PLACE, 4'd15, 4'd15, 4'd15, 4'd15);
        // col and row must not steer a place
        send_cmd(CMD_PLACE, 4'd15, 4'd15, 4'd10, 4'd1);
        send_cmd(CMD_MARK, 4'd0, 4'd0, 4'd3, 4'd2);
        send_cmd(CMD_MARK, 4'd1, 4'd1, 4'd2, 4'd2);
        send_cmd(CMD_PLACE, 4'd7, 4'd3, 4'd3, 4'd3);
        send_cmd(CMD_NONE, 4'd15, 4'd15, 4'd15, 4'd15);
        send_cmd(CMD_NONE, 4'd0, 4'd0, 4'd1, 4'd1);
        send_cmd(CMD_MARK, 4'd0, 4'd0, 4'd10, 4'd10);
        send_cmd(CMD_PLACE, 4'd0, 4'd0, 4'd1, 4'd1);
        send_cmd(CMD_CLEAR, 4'd0, 4'd0, 4'd1, 4'd1);
    endtask

    // Runs that start from a cleared grid and fill it, with some noise mixed in
    task automatic test_random_traffic(int n_items, int gap_pct, int stall_pct);
        int   sent;
        int   pick;
        int   w;
        int   h;
        cmd_t cmd;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            send_cmd(CMD_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     4'($urandom_range(15)), 4'($urandom_range(15)));
            sent++;
            repeat ($urandom_range(8, 40)) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    // Mostly small blocks so the grid fills gradually
                    w = ($urandom_range(9) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 4);
                    h = ($urandom_range(9) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 4);
                    send_cmd(CMD_PLACE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             4'(w), 4'(h));
                end else if (pick < 82) begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 3);
                    send_cmd(CMD_MARK, 4'($urandom_range(0, GRID - w)),
                             4'($urandom_range(0, GRID - h)), 4'(w), 4'(h));
                end else begin
                    cmd = cmd_t'($urandom_range(1, 3));
                    send_cmd(cmd, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             4'($urandom_range(15)), 4'($urandom_range(15)));
                end
                sent++;
            end
        end
    endtask

    // Stall the result side long enough to fill the block, then pause and drain
    task automatic test_output_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        recv_hold      = HOLD_CYCLES;
        send_cmd(CMD_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0);
        repeat (30) begin
            send_cmd(CMD_PLACE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)));
        end
        idle_sender();
        wait_for_drain();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_cmd    <= CMD_CLEAR;
        s_col    <= '0;
        s_row    <= '0;
        s_width  <= '0;
        s_height <= '0;
        for (int r = 0; r < GRID; r++) occ_map[r] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_backpressure();
        test_random_traffic(260, 16, 78);
        test_random_traffic(260, 78, 16);
        test_random_traffic(260, 0, 0);

        // Let the last results out, then allow for any stray ones
        idle_sender();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results: %0d clears, %0d marks and %0d places accepted,",
                 n_checked, n_clear, n_mark_ok, n_place_ok);
        $display("%0d commands refused (bad size, off grid, no room or unused code).",
                 n_rejected);
        if (err_count == 0) begin
            $display("tb_grid_first_fit_rect_placer: PASS");
        end else begin
            $display("tb_grid_first_fit_rect_placer: FAIL");
        end
        $finish;
    end

endmodule
